### sv/rmj_pkg.sv
// Package for the radar measurement Jacobian: widths, stage counts, carried
// records and the output saturation function. No dependencies.
package rmj_pkg;

  localparam int DATA_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int MINR_W     = 17;
  localparam logic [MINR_W-1:0] MINR_RESET = 17'd1;
  localparam int SQ_W       = 2 * DATA_W;          // sum of squares
  localparam int SQRT_STEPS = DATA_W;              // one root bit per stage
  localparam int AB_QW      = FRAC_BITS + 1;       // px/r, py/r never exceed one
  localparam int BR_QW      = DATA_W;              // bearing quotient bits
  localparam int PROD_W     = DATA_W + AB_QW + 1;  // velocity times unit vector
  localparam int W_W        = PROD_W + 1;          // difference of two products
  localparam int QC_W       = 46;                  // clamped rate quotient
  localparam logic [W_W-1:0] Q_CLAMP = W_W'(1) << (QC_W - 1);
  localparam int RATE_PW    = AB_QW + QC_W;

  typedef struct packed {
    logic                     px_neg;
    logic                     py_neg;
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vy;
    logic [DATA_W-1:0]        apx;
    logic [DATA_W-1:0]        apy;
  } base_t;

  typedef struct packed {
    logic               too_close;
    logic               px_neg;
    logic               py_neg;
    logic [DATA_W-1:0]  r;
    logic [AB_QW-1:0]   a_mag;
    logic [AB_QW-1:0]   b_mag;
    logic [BR_QW-1:0]   brx_q;
    logic               brx_ovf;
    logic [BR_QW-1:0]   bry_q;
    logic               bry_ovf;
  } mid_t;

  // Saturate a sign and magnitude pair to a two's complement word.
  function automatic logic [DATA_W-1:0] sat_out(input logic neg, input logic [63:0] mag);
    logic [63:0] lim;
    lim = 64'(1) << (DATA_W - 1);
    if (!neg) begin
      if (mag > lim - 64'd1) return DATA_W'(lim - 64'd1);
      return mag[DATA_W-1:0];
    end
    if (mag > lim) return DATA_W'(lim);
    return DATA_W'(64'd0 - mag);
  endfunction

endpackage

### sv/radar_measurement_jacobian.sv
// Radar measurement Jacobian, one fully pipelined module; depends on rmj_pkg.
// Depth: the result is presented after the input transfer passes 125 register
// stages: 3 square/sum, 32 square root, 33 divide, 2 velocity product, 52 rate divide,
// 2 clamp/product, 1 output. Throughput: one state vector per cycle, set by the
// single pipeline that advances whenever the output register is empty or taken.
// Reset (rst_n low, synchronous) clears every valid bit and sets min_range to 1.
module radar_measurement_jacobian (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [rmj_pkg::DATA_W-1:0]  in_pos_x,
  input  logic signed [rmj_pkg::DATA_W-1:0]  in_pos_y,
  input  logic signed [rmj_pkg::DATA_W-1:0]  in_vel_x,
  input  logic signed [rmj_pkg::DATA_W-1:0]  in_vel_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [rmj_pkg::DATA_W-1:0]  out_range_dpx,
  output logic signed [rmj_pkg::DATA_W-1:0]  out_range_dpy,
  output logic signed [rmj_pkg::DATA_W-1:0]  out_bearing_dpx,
  output logic signed [rmj_pkg::DATA_W-1:0]  out_bearing_dpy,
  output logic signed [rmj_pkg::DATA_W-1:0]  out_rate_dpx,
  output logic signed [rmj_pkg::DATA_W-1:0]  out_rate_dpy,
  output logic signed [rmj_pkg::DATA_W-1:0]  out_rate_dvx,
  output logic signed [rmj_pkg::DATA_W-1:0]  out_rate_dvy,
  output logic                               out_range_too_small,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rmj_pkg::MINR_W-1:0]         cfg_min_range
);
  import rmj_pkg::*;

  // Global advance: the whole pipe moves unless the output register is held.
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Minimum range register; always ready to take a write.
  logic [MINR_W-1:0] min_range_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_range_r <= MINR_RESET;
    end else if (cfg_valid) begin
      min_range_r <= cfg_min_range;
    end
  end

  // ---------------- Stage 0: capture, take magnitudes ----------------
  logic  s0_v_r;
  base_t s0_b_r, s0_b_nxt;
  always_comb begin
    s0_b_nxt.px_neg = in_pos_x[DATA_W-1];
    s0_b_nxt.py_neg = in_pos_y[DATA_W-1];
    s0_b_nxt.vx     = in_vel_x;
    s0_b_nxt.vy     = in_vel_y;
    s0_b_nxt.apx    = in_pos_x[DATA_W-1] ? DATA_W'(-in_pos_x) : DATA_W'(in_pos_x);
    s0_b_nxt.apy    = in_pos_y[DATA_W-1] ? DATA_W'(-in_pos_y) : DATA_W'(in_pos_y);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s0_v_r <= 1'b0;
    else if (en) s0_v_r <= in_valid;
    if (en) s0_b_r <= s0_b_nxt;
  end

  // ---------------- Stage 1: squares ----------------
  logic            s1_v_r;
  base_t           s1_b_r;
  logic [SQ_W-1:0] s1_sqx_r, s1_sqy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= s0_v_r;
    if (en) begin
      s1_b_r   <= s0_b_r;
      s1_sqx_r <= SQ_W'(s0_b_r.apx) * SQ_W'(s0_b_r.apx);
      s1_sqy_r <= SQ_W'(s0_b_r.apy) * SQ_W'(s0_b_r.apy);
    end
  end

  // ---------------- Square root: one result bit per stage ----------------
  logic            sq_v_r    [0:SQRT_STEPS];
  base_t           sq_b_r    [0:SQRT_STEPS];
  logic [SQ_W-1:0] sq_s_r    [0:SQRT_STEPS];
  logic [SQ_W-1:0] sq_rem_r  [0:SQRT_STEPS];
  logic [SQ_W-1:0] sq_root_r [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else if (en) sq_v_r[0] <= s1_v_r;
    if (en) begin
      sq_b_r[0]    <= s1_b_r;
      sq_s_r[0]    <= s1_sqx_r + s1_sqy_r;
      sq_rem_r[0]  <= s1_sqx_r + s1_sqy_r;
      sq_root_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    localparam int SH = SQ_W - 2 - 2 * i;
    localparam logic [SQ_W-1:0] ONE_BIT = SQ_W'(1) << SH;
    logic [SQ_W-1:0] trial;
    logic            take;
    assign trial = sq_root_r[i] + ONE_BIT;
    assign take  = sq_rem_r[i] >= trial;
    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[i+1] <= 1'b0;
      else if (en) sq_v_r[i+1] <= sq_v_r[i];
      if (en) begin
        sq_b_r[i+1]    <= sq_b_r[i];
        sq_s_r[i+1]    <= sq_s_r[i];
        sq_rem_r[i+1]  <= take ? sq_rem_r[i] - trial : sq_rem_r[i];
        sq_root_r[i+1] <= take ? (sq_root_r[i] >> 1) + ONE_BIT : sq_root_r[i] >> 1;
      end
    end
  end

  // ---------------- Divide phase: px/r, py/r and both bearing terms ----------------
  // Restoring division; the unit-vector quotients finish early and then hold.
  localparam int DV_STEPS = BR_QW;
  logic                dv_v_r     [0:DV_STEPS];
  logic                dv_small_r [0:DV_STEPS];
  base_t               dv_b_r     [0:DV_STEPS];
  logic [DATA_W-1:0]   dv_r_r     [0:DV_STEPS];
  logic [SQ_W-1:0]     dv_s_r     [0:DV_STEPS];
  logic [DATA_W-1:0]   dv_arem_r  [0:DV_STEPS];
  logic [AB_QW-1:0]    dv_aq_r    [0:DV_STEPS];
  logic [DATA_W-1:0]   dv_brem_r  [0:DV_STEPS];
  logic [AB_QW-1:0]    dv_bq_r    [0:DV_STEPS];
  logic [SQ_W-1:0]     dv_xrem_r  [0:DV_STEPS];
  logic [BR_QW-1:0]    dv_xq_r    [0:DV_STEPS];
  logic                dv_xovf_r  [0:DV_STEPS];
  logic [SQ_W-1:0]     dv_yrem_r  [0:DV_STEPS];
  logic [BR_QW-1:0]    dv_yq_r    [0:DV_STEPS];
  logic                dv_yovf_r  [0:DV_STEPS];

  logic [DATA_W-1:0] root_fin;
  base_t             sq_fin;
  assign root_fin = sq_root_r[SQRT_STEPS][DATA_W-1:0];
  assign sq_fin   = sq_b_r[SQRT_STEPS];

  // Range check and set up of the four dividers.  The x bearing term divides
  // py, the y bearing term divides px; a numerator at or above s saturates.
  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (en) dv_v_r[0] <= sq_v_r[SQRT_STEPS];
    if (en) begin
      dv_small_r[0] <= root_fin <= DATA_W'(min_range_r);
      dv_b_r[0]     <= sq_fin;
      dv_r_r[0]     <= root_fin;
      dv_s_r[0]     <= sq_s_r[SQRT_STEPS];
      dv_arem_r[0]  <= sq_fin.apx >> 1;
      dv_aq_r[0]    <= '0;
      dv_brem_r[0]  <= sq_fin.apy >> 1;
      dv_bq_r[0]    <= '0;
      dv_xrem_r[0]  <= SQ_W'(sq_fin.apy);
      dv_xq_r[0]    <= '0;
      dv_xovf_r[0]  <= SQ_W'(sq_fin.apy) >= sq_s_r[SQRT_STEPS];
      dv_yrem_r[0]  <= SQ_W'(sq_fin.apx);
      dv_yq_r[0]    <= '0;
      dv_yovf_r[0]  <= SQ_W'(sq_fin.apx) >= sq_s_r[SQRT_STEPS];
    end
  end

  for (genvar k = 0; k < DV_STEPS; k++) begin : g_div
    logic [SQ_W:0]   xt, yt;
    logic            xge, yge;
    logic [DATA_W:0] at, bt;
    logic            age, bge;
    assign xt  = {dv_xrem_r[k], 1'b0};
    assign yt  = {dv_yrem_r[k], 1'b0};
    assign xge = xt >= {1'b0, dv_s_r[k]};
    assign yge = yt >= {1'b0, dv_s_r[k]};
    // Only the first step brings in a set bit: apx sits at bit FRAC_BITS.
    assign at  = {dv_arem_r[k], (k == 0) ? dv_b_r[k].apx[0] : 1'b0};
    assign bt  = {dv_brem_r[k], (k == 0) ? dv_b_r[k].apy[0] : 1'b0};
    assign age = at >= {1'b0, dv_r_r[k]};
    assign bge = bt >= {1'b0, dv_r_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[k+1] <= 1'b0;
      else if (en) dv_v_r[k+1] <= dv_v_r[k];
      if (en) begin
        dv_small_r[k+1] <= dv_small_r[k];
        dv_b_r[k+1]     <= dv_b_r[k];
        dv_r_r[k+1]     <= dv_r_r[k];
        dv_s_r[k+1]     <= dv_s_r[k];
        dv_xrem_r[k+1]  <= xge ? SQ_W'(xt - {1'b0, dv_s_r[k]}) : xt[SQ_W-1:0];
        dv_xq_r[k+1]    <= {dv_xq_r[k][BR_QW-2:0], xge};
        dv_xovf_r[k+1]  <= dv_xovf_r[k];
        dv_yrem_r[k+1]  <= yge ? SQ_W'(yt - {1'b0, dv_s_r[k]}) : yt[SQ_W-1:0];
        dv_yq_r[k+1]    <= {dv_yq_r[k][BR_QW-2:0], yge};
        dv_yovf_r[k+1]  <= dv_yovf_r[k];
      end
    end

    if (k < AB_QW) begin : g_ab
      always_ff @(posedge clk) begin
        if (en) begin
          dv_arem_r[k+1] <= age ? DATA_W'(at - {1'b0, dv_r_r[k]}) : at[DATA_W-1:0];
          dv_aq_r[k+1]   <= {dv_aq_r[k][AB_QW-2:0], age};
          dv_brem_r[k+1] <= bge ? DATA_W'(bt - {1'b0, dv_r_r[k]}) : bt[DATA_W-1:0];
          dv_bq_r[k+1]   <= {dv_bq_r[k][AB_QW-2:0], bge};
        end
      end
    end else begin : g_ab_hold
      always_ff @(posedge clk) begin
        if (en) begin
          dv_arem_r[k+1] <= dv_arem_r[k];
          dv_aq_r[k+1]   <= dv_aq_r[k];
          dv_brem_r[k+1] <= dv_brem_r[k];
          dv_bq_r[k+1]   <= dv_bq_r[k];
        end
      end
    end
  end

  // ---------------- Velocity products and their difference ----------------
  mid_t                     m1_m_nxt;
  logic signed [AB_QW:0]    a_s, b_s;
  logic                     m1_v_r, m2_v_r;
  mid_t                     m1_m_r, m2_m_r;
  logic signed [PROD_W-1:0] m1_pa_r, m1_pb_r;
  logic signed [W_W-1:0]    m2_w_r;

  always_comb begin
    m1_m_nxt.too_close = dv_small_r[DV_STEPS];
    m1_m_nxt.px_neg    = dv_b_r[DV_STEPS].px_neg;
    m1_m_nxt.py_neg    = dv_b_r[DV_STEPS].py_neg;
    m1_m_nxt.r         = dv_r_r[DV_STEPS];
    m1_m_nxt.a_mag     = dv_aq_r[DV_STEPS];
    m1_m_nxt.b_mag     = dv_bq_r[DV_STEPS];
    m1_m_nxt.brx_q     = dv_xq_r[DV_STEPS];
    m1_m_nxt.brx_ovf   = dv_xovf_r[DV_STEPS];
    m1_m_nxt.bry_q     = dv_yq_r[DV_STEPS];
    m1_m_nxt.bry_ovf   = dv_yovf_r[DV_STEPS];
    a_s = dv_b_r[DV_STEPS].px_neg ? -$signed({1'b0, dv_aq_r[DV_STEPS]})
                                  :  $signed({1'b0, dv_aq_r[DV_STEPS]});
    b_s = dv_b_r[DV_STEPS].py_neg ? -$signed({1'b0, dv_bq_r[DV_STEPS]})
                                  :  $signed({1'b0, dv_bq_r[DV_STEPS]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= dv_v_r[DV_STEPS];
      m2_v_r <= m1_v_r;
    end
    if (en) begin
      m1_m_r  <= m1_m_nxt;
      m1_pa_r <= dv_b_r[DV_STEPS].vy * a_s;
      m1_pb_r <= dv_b_r[DV_STEPS].vx * b_s;
      m2_m_r  <= m1_m_r;
      m2_w_r  <= W_W'(m1_pb_r) - W_W'(m1_pa_r);
    end
  end

  // ---------------- Rate divide: |w| / r, one quotient bit per stage ----------------
  logic              rd_v_r    [0:W_W];
  mid_t              rd_m_r    [0:W_W];
  logic              rd_wneg_r [0:W_W];
  logic [DATA_W-1:0] rd_rem_r  [0:W_W];
  logic [W_W-1:0]    rd_num_r  [0:W_W];
  logic [W_W-1:0]    rd_q_r    [0:W_W];

  always_ff @(posedge clk) begin
    if (!rst_n) rd_v_r[0] <= 1'b0;
    else if (en) rd_v_r[0] <= m2_v_r;
    if (en) begin
      rd_m_r[0]    <= m2_m_r;
      rd_wneg_r[0] <= m2_w_r[W_W-1];
      rd_rem_r[0]  <= '0;
      rd_num_r[0]  <= m2_w_r[W_W-1] ? W_W'(-m2_w_r) : W_W'(m2_w_r);
      rd_q_r[0]    <= '0;
    end
  end

  for (genvar j = 0; j < W_W; j++) begin : g_rdiv
    logic [DATA_W:0] t;
    logic            ge;
    assign t  = {rd_rem_r[j], rd_num_r[j][W_W-1]};
    assign ge = t >= {1'b0, rd_m_r[j].r};
    always_ff @(posedge clk) begin
      if (!rst_n) rd_v_r[j+1] <= 1'b0;
      else if (en) rd_v_r[j+1] <= rd_v_r[j];
      if (en) begin
        rd_m_r[j+1]    <= rd_m_r[j];
        rd_wneg_r[j+1] <= rd_wneg_r[j];
        rd_rem_r[j+1]  <= ge ? DATA_W'(t - {1'b0, rd_m_r[j].r}) : t[DATA_W-1:0];
        rd_num_r[j+1]  <= rd_num_r[j] << 1;
        rd_q_r[j+1]    <= {rd_q_r[j][W_W-2:0], ge};
      end
    end
  end

  // ---------------- Clamp the rate quotient, then scale by the unit vector ----------------
  logic                c1_v_r, c2_v_r;
  mid_t                c1_m_r, c2_m_r;
  logic                c1_wneg_r, c2_wneg_r;
  logic [QC_W-1:0]     c1_qc_r;
  logic [RATE_PW-1:0]  c2_p4_r, c2_p5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r <= 1'b0;
      c2_v_r <= 1'b0;
    end else if (en) begin
      c1_v_r <= rd_v_r[W_W];
      c2_v_r <= c1_v_r;
    end
    if (en) begin
      c1_m_r    <= rd_m_r[W_W];
      c1_wneg_r <= rd_wneg_r[W_W];
      c1_qc_r   <= (rd_q_r[W_W] > Q_CLAMP) ? QC_W'(Q_CLAMP) : rd_q_r[W_W][QC_W-1:0];
      c2_m_r    <= c1_m_r;
      c2_wneg_r <= c1_wneg_r;
      c2_p4_r   <= RATE_PW'(c1_m_r.b_mag) * RATE_PW'(c1_qc_r);
      c2_p5_r   <= RATE_PW'(c1_m_r.a_mag) * RATE_PW'(c1_qc_r);
    end
  end

  // ---------------- Output register ----------------
  logic [DATA_W-1:0] rdpx_r, rdpy_r, bdpx_r, bdpy_r, tdpx_r, tdpy_r;
  logic [DATA_W-1:0] rdpx_nxt, rdpy_nxt, bdpx_nxt, bdpy_nxt, tdpx_nxt, tdpy_nxt;
  logic              small_r;

  always_comb begin
    rdpx_nxt = sat_out(c2_m_r.px_neg, 64'(c2_m_r.a_mag));
    rdpy_nxt = sat_out(c2_m_r.py_neg, 64'(c2_m_r.b_mag));
    // Minus py over s: negative when py is positive.
    bdpx_nxt = sat_out(!c2_m_r.py_neg, c2_m_r.brx_ovf ? '1 : 64'(c2_m_r.brx_q));
    bdpy_nxt = sat_out(c2_m_r.px_neg, c2_m_r.bry_ovf ? '1 : 64'(c2_m_r.bry_q));
    tdpx_nxt = sat_out(c2_m_r.py_neg ^ c2_wneg_r, 64'(c2_p4_r >> FRAC_BITS));
    tdpy_nxt = sat_out(!(c2_m_r.px_neg ^ c2_wneg_r), 64'(c2_p5_r >> FRAC_BITS));
    if (c2_m_r.too_close) begin
      // Too close to divide: zero the whole matrix.
      rdpx_nxt = '0;
      rdpy_nxt = '0;
      bdpx_nxt = '0;
      bdpy_nxt = '0;
      tdpx_nxt = '0;
      tdpy_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= c2_v_r;
    if (en) begin
      rdpx_r  <= rdpx_nxt;
      rdpy_r  <= rdpy_nxt;
      bdpx_r  <= bdpx_nxt;
      bdpy_r  <= bdpy_nxt;
      tdpx_r  <= tdpx_nxt;
      tdpy_r  <= tdpy_nxt;
      small_r <= c2_m_r.too_close;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_range_dpx       = rdpx_r;
  assign out_range_dpy       = rdpy_r;
  assign out_bearing_dpx     = bdpx_r;
  assign out_bearing_dpy     = bdpy_r;
  assign out_rate_dpx        = tdpx_r;
  assign out_rate_dpy        = tdpy_r;
  assign out_rate_dvx        = rdpx_r;  // last row repeats the unit vector
  assign out_rate_dvy        = rdpy_r;
  assign out_range_too_small = small_r;

  // ---------------- Assertions ----------------
  a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
    sq_v_r[SQRT_STEPS] |-> sq_root_r[SQRT_STEPS][SQ_W-1:DATA_W] == '0)
    else $error("square root exceeds the data width");

  a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dv_v_r[DV_STEPS] && !dv_small_r[DV_STEPS] |->
      dv_aq_r[DV_STEPS] <= AB_QW'(1 << FRAC_BITS) && dv_bq_r[DV_STEPS] <= AB_QW'(1 << FRAC_BITS))
    else $error("unit vector component above one");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    c1_v_r |-> W_W'(c1_qc_r) <= Q_CLAMP)
    else $error("rate quotient not clamped");

  a_small_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && small_r |->
      rdpx_r == '0 && rdpy_r == '0 && bdpx_r == '0 && bdpy_r == '0 &&
      tdpx_r == '0 && tdpy_r == '0)
    else $error("matrix not zero with range too small");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> out_valid_r && $stable(tdpx_r) && $stable(small_r))
    else $error("output changed while held");

endmodule

### tb/sv/radar_measurement_jacobian_tb.sv
// Self-checking testbench for radar_measurement_jacobian: random and directed
// state vectors, its own Jacobian predictor and a scoreboard. Depends on rmj_pkg.
`timescale 1ns / 100ps

module radar_measurement_jacobian_tb;
  import rmj_pkg::*;

  typedef logic signed [DATA_W-1:0] word_t;

  // one tracking state, as offered on the input channel
  typedef struct packed {
    word_t px;
    word_t py;
    word_t vx;
    word_t vy;
  } track_t;

  // one Jacobian, as presented on the result channel
  typedef struct packed {
    word_t range_dpx;
    word_t range_dpy;
    word_t bearing_dpx;
    word_t bearing_dpy;
    word_t rate_dpx;
    word_t rate_dpy;
    word_t rate_dvx;
    word_t rate_dvy;
    logic  too_small;
  } jacobian_t;

  localparam int FB       = 16;
  localparam int LONG_HOLD = 400;   // receiver hold-off, well past pipeline depth

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  word_t             in_pos_x = '0, in_pos_y = '0, in_vel_x = '0, in_vel_y = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  word_t             out_range_dpx, out_range_dpy, out_bearing_dpx, out_bearing_dpy;
  word_t             out_rate_dpx, out_rate_dpy, out_rate_dvx, out_rate_dvy;
  logic              out_range_too_small;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [MINR_W-1:0] cfg_min_range = '0;

  radar_measurement_jacobian DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_pos_x            (in_pos_x),
    .in_pos_y            (in_pos_y),
    .in_vel_x            (in_vel_x),
    .in_vel_y            (in_vel_y),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_range_dpx       (out_range_dpx),
    .out_range_dpy       (out_range_dpy),
    .out_bearing_dpx     (out_bearing_dpx),
    .out_bearing_dpy     (out_bearing_dpy),
    .out_rate_dpx        (out_rate_dpx),
    .out_rate_dpy        (out_rate_dpy),
    .out_rate_dvx        (out_rate_dvx),
    .out_rate_dvy        (out_rate_dvy),
    .out_range_too_small (out_range_too_small),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_min_range       (cfg_min_range)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  track_t            track_q[$];      // states waiting to be offered
  jacobian_t         jacobian_q[$];   // predicted Jacobians, oldest first
  logic [MINR_W-1:0] min_range_copy = 17'd1;
  int                errors = 0;
  int                n_sent = 0;
  int                n_checked = 0;
  int                n_small = 0;
  bit                sender_hold = 1'b0;
  bit                long_hold_req = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? 64'd0 - longint'(v) : 64'(v);
  endfunction

  // integer square root, rounded down, one result bit per pass
  function automatic longint unsigned floor_root(longint unsigned s);
    longint unsigned rem, root, bitv;
    rem  = s;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  -= root + bitv;
        root  = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // clamp a sign and magnitude pair into one signed output word
  function automatic word_t clamp_word(bit neg, longint unsigned mag);
    longint unsigned lim;
    lim = 64'd1 << (DATA_W - 1);
    if (!neg) return (mag > lim - 1) ? word_t'(lim - 1) : word_t'(mag);
    if (mag > lim) mag = lim;
    return word_t'(64'd0 - mag);
  endfunction

  function automatic jacobian_t radar_jacobian(track_t t, logic [MINR_W-1:0] min_r);
    jacobian_t       j;
    longint          px, py, vx, vy, a, b, w, q;
    longint unsigned apx, apy, s, r;
    j  = '0;
    px = t.px;
    py = t.py;
    vx = t.vx;
    vy = t.vy;
    apx = magnitude(px);
    apy = magnitude(py);
    s   = apx * apx + apy * apy;
    r   = floor_root(s);
    // too close to the sensor: refuse to divide, whole matrix zero
    if (r <= 64'(min_r)) begin
      j.too_small = 1'b1;
      return j;
    end
    a = longint'((apx << FB) / r);
    if (px < 0) a = -a;
    b = longint'((apy << FB) / r);
    if (py < 0) b = -b;
    j.range_dpx   = clamp_word(a < 0, magnitude(a));
    j.range_dpy   = clamp_word(b < 0, magnitude(b));
    j.bearing_dpx = clamp_word(py > 0, (apy << (2 * FB)) / s);
    j.bearing_dpy = clamp_word(px < 0, (apx << (2 * FB)) / s);
    w = vx * b - vy * a;
    q = w / longint'(r);
    // hold the rate quotient within +-2^45 so the products saturate cleanly
    if (q > (64'sd1 <<< 45)) q = 64'sd1 <<< 45;
    if (q < -(64'sd1 <<< 45)) q = -(64'sd1 <<< 45);
    j.rate_dpx = clamp_word((b < 0) != (q < 0), (magnitude(b) * magnitude(q)) >> FB);
    j.rate_dpy = clamp_word((a < 0) == (q < 0), (magnitude(a) * magnitude(q)) >> FB);
    j.rate_dvx = j.range_dpx;
    j.rate_dvy = j.range_dpy;
    return j;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of transfers separated by random gaps
  // ---------------------------------------------------------------------------

  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    bit     nxt_valid;
    track_t nxt;
    nxt_valid = 1'b0;
    nxt       = {in_pos_x, in_pos_y, in_vel_x, in_vel_y};
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        jacobian_q.push_back(radar_jacobian(track_q.pop_front(), min_range_copy));
        n_sent++;
      end
      if (in_valid && in_stall) begin
        // stalled transfer: hold the payload
        nxt_valid = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (track_q.size() > 0 && !sender_hold) begin
        nxt_valid = 1'b1;
        nxt       = track_q[0];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(0, 15);
          gap_left   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_valid <= nxt_valid;
    {in_pos_x, in_pos_y, in_vel_x, in_vel_y} <= nxt;
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall pattern of its own, scoreboard compare on each transfer
  // ---------------------------------------------------------------------------

  int  cyc       = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    jacobian_t got, want;
    bit        nxt_stall;
    cyc++;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_range_dpx, out_range_dpy, out_bearing_dpx, out_bearing_dpy,
             out_rate_dpx, out_rate_dpy, out_rate_dvx, out_rate_dvy, out_range_too_small};
      if (jacobian_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
      end else begin
        want = jacobian_q.pop_front();
        n_checked++;
        if (want.too_small) n_small++;
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch range_dpx exp %h got %h, range_dpy exp %h got %h",
                   $realtime, want.range_dpx, got.range_dpx, want.range_dpy, got.range_dpy);
          $display("%0t:   bearing exp %h %h got %h %h, rate exp %h %h got %h %h",
                   $realtime, want.bearing_dpx, want.bearing_dpy, got.bearing_dpx,
                   got.bearing_dpy, want.rate_dpx, want.rate_dpy, got.rate_dpx, got.rate_dpy);
          $display("%0t:   dv exp %h %h got %h %h, too_small exp %b got %b", $realtime,
                   want.rate_dvx, want.rate_dvy, got.rate_dvx, got.rate_dvy,
                   want.too_small, got.too_small);
        end
      end
    end
    // one long hold-off on request, else a pattern chosen by bits 8:7 of the cycle count
    if (long_hold_req && !hold_done) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      nxt_stall = 1'b1;
    end else begin
      case ((cyc >> 7) % 4)
        0:       nxt_stall = 1'b0;
        1:       nxt_stall = $urandom_range(0, 9) < 3;
        2:       nxt_stall = $urandom_range(0, 9) < 7;
        default: nxt_stall = cyc[2];
      endcase
    end
    out_stall <= nxt_stall;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic word_t rand_word();
    word_t v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0, 1:    return v;
      2:       return v >>> $urandom_range(1, 31);          // small, either sign
      3:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      4:       return word_t'($urandom_range(0, 8)) - 4;     // near the origin
      default: return v >>> $urandom_range(8, 20);
    endcase
  endfunction

  task automatic add_track(word_t px, word_t py, word_t vx, word_t vy);
    track_t t;
    t = {px, py, vx, vy};
    track_q.push_back(t);
  endtask

  task automatic add_random(int n);
    repeat (n) add_track(rand_word(), rand_word(), rand_word(), rand_word());
  endtask

  // wait until every queued state has been sent and every predicted result checked
  task automatic drain();
    while (track_q.size() > 0 || in_valid || jacobian_q.size() > 0) @(posedge clk);
  endtask

  // let everything queued run out first, then hold the sender over the write
  task automatic write_min_range(logic [MINR_W-1:0] v);
    drain();
    sender_hold = 1'b1;
    @(posedge clk);
    cfg_valid     <= 1'b1;
    cfg_min_range <= v;
    do @(posedge clk); while (!cfg_ready);
    min_range_copy = v;
    cfg_valid <= 1'b0;
    sender_hold = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: origin, range boundary, extremes, clamped rate
    add_track(0, 0, 32'sh7fffffff, 32'sh80000000);
    add_track(1, 0, 5, 5);                               // r equals min_range
    add_track(2, 0, 32'sh7fffffff, 32'sh7fffffff);       // just above
    add_track(0, -2, 32'sh80000000, 1);
    add_track(2, 2, 32'sh7fffffff, 32'sh80000000);       // rate quotient clamps
    add_track(-2, -2, 32'sh80000000, 32'sh7fffffff);
    add_track(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    add_track(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    add_track(32'sh80000000, 0, 0, 32'sh7fffffff);
    add_track(0, 32'sh7fffffff, 32'sh7fffffff, 0);
    add_track(32'sh10000, 32'sh10000, 32'sh10000, -32'sh10000);
    add_track(-32'sh30000, 32'sh40000, 32'sh20000, 32'sh50000);
    add_track(3, -4, -1, 1);
    add_track(-1, 1, 0, 0);
    add_track(32'shffff, 0, 1, -1);
    add_random(200);

    write_min_range(17'd0);
    add_track(0, 0, 1, 1);                               // origin with zero minimum
    add_track(1, 0, -1, 32'sh7fffffff);
    add_random(250);
    long_hold_req = 1'b1;                                // fill the pipeline
    add_random(250);

    write_min_range(17'h10000);                          // minimum of 2^16
    add_track(32'sh10000, 0, 3, 3);
    add_track(32'sh10001, 0, 3, 3);
    add_track(-32'sh10001, 0, 32'sh7fffffff, 32'sh7fffffff);
    add_random(250);

    write_min_range(17'($urandom));
    add_random(250);
    write_min_range(17'd100);
    add_random(120);
    write_min_range(17'd1);
    add_random(120);

    drain();
    repeat (150) @(posedge clk);
    $display("Checked %0d Jacobians (%0d refused for short range) over six min_range settings",
             n_checked, n_small);
    if (errors == 0 && jacobian_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out with %0d results outstanding", jacobian_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule
